FILE: rtl/servo_actuator_command_sequencer_core_assert.svh
// Assertion macros for the servo command sequencer core.
// Included by the top level; no other dependencies.
`ifndef SERVO_ACTUATOR_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`define SERVO_ACTUATOR_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SACS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SACS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SACS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define SACS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/sacs_pkg.sv
// Shared types, codes and helpers of the servo command sequencer.
// No dependencies; used by every module of the block but sacs_fifo.
`timescale 1ns / 1ps
package sacs_pkg;

    localparam int CMD_DEPTH_DEF = 4;
    localparam int RES_DEPTH_DEF = 2;

    // opcodes
    localparam logic [2:0] OP_POSITION = 3'd0;
    localparam logic [2:0] OP_PULSE    = 3'd1;
    localparam logic [2:0] OP_OSC      = 3'd2;
    localparam logic [2:0] OP_OFF      = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;
    localparam logic [2:0] OP_INIT     = 3'd5;

    // modes
    localparam logic [2:0] MODE_STRIKE   = 3'd0;
    localparam logic [2:0] MODE_COMB     = 3'd1;
    localparam logic [2:0] MODE_PITCH    = 3'd2;
    localparam logic [2:0] MODE_HIHAT    = 3'd3;
    localparam logic [2:0] MODE_MUTE     = 3'd4;
    localparam logic [2:0] MODE_POSITION = 3'd5;

    // register indexes
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_ANGLE_MIN  = 3'd1;
    localparam logic [2:0] REG_ANGLE_MAX  = 3'd2;
    localparam logic [2:0] REG_ANGLE_REST = 3'd3;
    localparam logic [2:0] REG_MIRROR     = 3'd4;
    localparam logic [2:0] REG_ENABLE     = 3'd5;
    localparam logic [2:0] REG_SPLASH_US  = 3'd6;
    localparam logic [2:0] REG_MAX_ON_US  = 3'd7;

    localparam int CFG_DATA_W = 24;

    // register defaults
    localparam logic [7:0]  RST_ANGLE_MIN  = 8'd0;
    localparam logic [7:0]  RST_ANGLE_MAX  = 8'd180;
    localparam logic [7:0]  RST_ANGLE_REST = 8'd90;
    localparam logic [23:0] RST_SPLASH_US  = 24'd100000;
    localparam logic [23:0] RST_MAX_ON_US  = 24'd5000000;

    localparam int VAL_TOP     = 127;
    localparam int VAL_MID     = 64;
    localparam int OSC_SLOW_US = 250000;
    localparam int OSC_FAST_US = 30000;

    // period = SLOW - floor(k*SPAN/(TOP-1)), k = value-1, split as k*Q + floor(k*R/(TOP-1))
    localparam int OSC_SPAN   = OSC_SLOW_US - OSC_FAST_US;
    localparam int OSC_STEP_Q = OSC_SPAN / (VAL_TOP - 1);
    localparam int OSC_REM    = OSC_SPAN - OSC_STEP_Q * (VAL_TOP - 1);

    // x/127 for x below 2^15 as (x*DIV_MUL) >> DIV_SHIFT, exact over that range
    localparam int DIV_SHIFT = 22;
    localparam int DIV_MUL   = ((1 << DIV_SHIFT) + VAL_TOP - 1) / VAL_TOP;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  angle_min;
        logic [7:0]  angle_max;
        logic [7:0]  angle_rest;
        logic        mirror;
        logic        enable;
        logic [23:0] splash_us;
        logic [23:0] max_on_us;
    } t_cfg;

    typedef enum logic [3:0] {
        K_NOP,
        K_POS,
        K_POS_HIHAT,
        K_PULSE,
        K_PULSE_HIHAT,
        K_PULSE_MUTE,
        K_OSC,
        K_STOP,
        K_TICK,
        K_INIT
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  angle;   // target angle, fitted (hi-hat pulse: unfitted splash return angle)
        logic [17:0] period;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        logic       move;
        logic [7:0] angle;
        logic       timeout_stop;
        logic       active;
    } t_res;

    // clamp to min..max, then mirror inside the range; 8-bit wrap
    function automatic logic [7:0] write_angle(input logic [7:0] a, input t_cfg cfg);
        logic [7:0] v;
        v = a;
        if (v < cfg.angle_min) v = cfg.angle_min;
        if (v > cfg.angle_max) v = cfg.angle_max;
        if (cfg.mirror) v = cfg.angle_max - (v - cfg.angle_min);
        return v;
    endfunction

endpackage

FILE: rtl/sacs_fifo.sv
// Small synchronous queue with registered storage and show-ahead read.
// Depends on nothing; used for the command and result queues.
`timescale 1ns / 1ps
module sacs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/sacs_front.sv
// Front end: accepts requests, classifies them, computes target angles and oscillation periods.
// Depends on sacs_pkg; feeds the command queue.
`timescale 1ns / 1ps
module sacs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sacs_pkg::t_cfg  i_cfg,
    input  logic            i_push,
    output logic            o_full,
    input  logic [2:0]      i_opcode,
    input  logic [6:0]      i_value,
    input  logic [31:0]     i_now_us,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output sacs_pkg::t_cmd  o_cmd
);
    typedef enum logic [1:0] {
        T_SCALE,
        T_PITCH,
        T_MIN,
        T_MAX
    } t_tsel;

    // span of the angle range, for stages A and C; user must keep config static in flight (unenforced)
    logic [8:0] w_d;
    logic       w_neg;
    logic [7:0] w_abs;
    logic [8:0] w_sum;

    assign w_d   = {1'b0, i_cfg.angle_max} - {1'b0, i_cfg.angle_min};
    assign w_neg = w_d[8];
    assign w_abs = w_neg ? 8'(-w_d) : w_d[7:0];
    assign w_sum = {1'b0, i_cfg.angle_min} + {1'b0, i_cfg.angle_max};

    // stage A: accepted request
    logic        r_a_valid;
    logic [2:0]  r_a_op;
    logic [6:0]  r_a_val;
    logic [31:0] r_a_now;
    logic [6:0]  r_last_cc;

    // stage B: product
    logic                 r_b_valid;
    sacs_pkg::t_kind      r_b_kind;
    t_tsel                r_b_tsel;
    logic [14:0]          r_b_prod;
    logic [6:0]           r_b_val;
    logic [31:0]          r_b_now;

    // stage C: quotient and period
    logic                 r_c_valid;
    sacs_pkg::t_kind      r_c_kind;
    t_tsel                r_c_tsel;
    logic [7:0]           r_c_q;
    logic [17:0]          r_c_period;
    logic [31:0]          r_c_now;

    logic w_a_rdy, w_b_rdy, w_c_rdy;

    assign w_c_rdy = !r_c_valid || i_cmd_ready;
    assign w_b_rdy = !r_b_valid || w_c_rdy;
    assign w_a_rdy = !r_a_valid || w_b_rdy;
    assign o_full  = !w_a_rdy;

    // ---- stage A: classification and multiply
    sacs_pkg::t_kind w_kind;
    t_tsel           w_tsel;
    logic [6:0]      w_x;
    logic [7:0]      w_mag;
    logic [14:0]     w_prod;

    always_comb begin
        w_kind = sacs_pkg::K_NOP;
        w_tsel = T_SCALE;
        unique case (r_a_op)
            sacs_pkg::OP_POSITION: begin
                if (i_cfg.enable) begin
                    w_kind = sacs_pkg::K_POS;
                    if (i_cfg.mode == sacs_pkg::MODE_PITCH) begin
                        w_tsel = T_PITCH;
                    end else if (i_cfg.mode == sacs_pkg::MODE_HIHAT) begin
                        w_kind = sacs_pkg::K_POS_HIHAT;
                    end else if (i_cfg.mode == sacs_pkg::MODE_MUTE) begin
                        w_tsel = (r_a_val < 7'(sacs_pkg::VAL_MID)) ? T_MIN : T_MAX;
                    end
                end
            end
            sacs_pkg::OP_PULSE: begin
                if (i_cfg.enable) begin
                    if (i_cfg.mode == sacs_pkg::MODE_HIHAT) begin
                        w_kind = sacs_pkg::K_PULSE_HIHAT;
                    end else if (i_cfg.mode == sacs_pkg::MODE_MUTE) begin
                        w_kind = sacs_pkg::K_PULSE_MUTE;
                    end else begin
                        w_kind = sacs_pkg::K_PULSE;
                    end
                end
            end
            sacs_pkg::OP_OSC: begin
                if (i_cfg.enable && (i_cfg.mode == sacs_pkg::MODE_STRIKE ||
                                     i_cfg.mode == sacs_pkg::MODE_COMB)) begin
                    w_kind = (r_a_val == '0) ? sacs_pkg::K_STOP : sacs_pkg::K_OSC;
                end
            end
            sacs_pkg::OP_OFF: begin
                if (i_cfg.enable) w_kind = sacs_pkg::K_STOP;
            end
            sacs_pkg::OP_TICK: w_kind = sacs_pkg::K_TICK;
            sacs_pkg::OP_INIT: w_kind = sacs_pkg::K_INIT;
            default:           w_kind = sacs_pkg::K_NOP;
        endcase
    end

    // hi-hat pulse scales the last controller value, everything else the item value
    assign w_x    = (w_kind == sacs_pkg::K_PULSE_HIHAT) ? r_last_cc : r_a_val;
    assign w_mag  = (w_tsel == T_PITCH) ? {w_abs[7:1], 1'b0} : w_abs;
    assign w_prod = {8'd0, w_x} * {7'd0, w_mag};

    // ---- stage B: divide by the value span, oscillation period
    logic [30:0] w_recip;
    logic [7:0]  w_q;
    logic [6:0]  w_k;
    logic [2:0]  w_rem;
    logic [17:0] w_step;

    assign w_recip = {16'd0, r_b_prod} * 31'(sacs_pkg::DIV_MUL);
    assign w_q     = 8'(w_recip >> sacs_pkg::DIV_SHIFT);
    assign w_k     = r_b_val - 7'd1;

    always_comb begin
        w_rem = '0;
        for (int j = 1; j <= sacs_pkg::OSC_REM; j++) begin
            if (18'(w_k) * 18'(sacs_pkg::OSC_REM) >= 18'(j * (sacs_pkg::VAL_TOP - 1))) begin
                w_rem = w_rem + 3'd1;
            end
        end
    end

    assign w_step = 18'(w_k) * 18'(sacs_pkg::OSC_STEP_Q) + 18'(w_rem);

    // ---- stage C: signed result, pitch clamp, final angle
    logic [7:0]         w_scaled;
    logic [6:0]         w_half;
    logic signed [11:0] w_t;
    logic signed [11:0] w_tc;
    logic [7:0]         w_target;

    assign w_scaled = w_neg ? (i_cfg.angle_min - r_c_q) : (i_cfg.angle_min + r_c_q);
    assign w_half   = w_abs[7:1];
    assign w_t = $signed({4'd0, w_sum[8:1]}) +
                 (w_neg ? ($signed({5'd0, w_half}) - $signed({4'd0, r_c_q}))
                        : ($signed({4'd0, r_c_q}) - $signed({5'd0, w_half})));

    always_comb begin
        w_tc = w_t;
        if (w_tc < $signed({4'd0, i_cfg.angle_min})) w_tc = $signed({4'd0, i_cfg.angle_min});
        if (w_tc > $signed({4'd0, i_cfg.angle_max})) w_tc = $signed({4'd0, i_cfg.angle_max});
    end

    always_comb begin
        unique case (r_c_tsel)
            T_SCALE: w_target = w_scaled;
            T_PITCH: w_target = w_tc[7:0];
            T_MIN:   w_target = i_cfg.angle_min;
            T_MAX:   w_target = i_cfg.angle_max;
            default: w_target = w_scaled;
        endcase
    end

    // splash return angle goes out unfitted; it is clamped and mirrored when
    // the splash closes, under the registers in force then
    assign o_cmd_valid  = r_c_valid;
    assign o_cmd.kind   = r_c_kind;
    assign o_cmd.angle  = (r_c_kind == sacs_pkg::K_PULSE_HIHAT) ? w_target
                                                               : sacs_pkg::write_angle(w_target, i_cfg);
    assign o_cmd.period = r_c_period;
    assign o_cmd.now    = r_c_now;

    // ---- pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_last_cc <= '0;
        end else begin
            if (w_a_rdy) r_a_valid <= i_push;
            if (w_b_rdy) r_b_valid <= r_a_valid;
            if (w_c_rdy) r_c_valid <= r_b_valid;
            if (w_b_rdy && r_a_valid && w_kind == sacs_pkg::K_POS_HIHAT) begin
                r_last_cc <= r_a_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_rdy) begin
            r_a_op  <= i_opcode;
            r_a_val <= i_value;
            r_a_now <= i_now_us;
        end
        if (w_b_rdy) begin
            r_b_kind <= w_kind;
            r_b_tsel <= w_tsel;
            r_b_prod <= w_prod;
            r_b_val  <= r_a_val;
            r_b_now  <= r_a_now;
        end
        if (w_c_rdy) begin
            r_c_kind   <= r_b_kind;
            r_c_tsel   <= r_b_tsel;
            r_c_q      <= w_q;
            r_c_period <= 18'(sacs_pkg::OSC_SLOW_US) - w_step;
            r_c_now    <= r_b_now;
        end
    end

endmodule

FILE: rtl/sacs_back.sv
// Back end: executes classified commands against the servo state.
// Depends on sacs_pkg; reads the command queue, writes the result queue.
`timescale 1ns / 1ps
module sacs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sacs_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    input  sacs_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_res_ready,
    output logic           o_res_push,
    output sacs_pkg::t_res o_res
);
    logic [7:0]  r_cur,        n_cur;
    logic        r_splash_on,  n_splash_on;
    logic [31:0] r_splash_st,  n_splash_st;
    logic [7:0]  r_splash_ret, n_splash_ret;
    logic        r_osc_run,    n_osc_run;
    logic        r_osc_phase,  n_osc_phase;
    logic [17:0] r_osc_period, n_osc_period;
    logic [31:0] r_osc_last,   n_osc_last;
    logic        r_act,        n_act;
    logic [31:0] r_act_st,     n_act_st;

    logic        w_fire, w_move, w_to;
    logic [7:0]  w_wa_min, w_wa_max, w_wa_rest, w_wa_ret;
    logic [8:0]  w_sum;
    logic        w_hold_mode;
    logic [31:0] w_osc_dt, w_spl_dt, w_act_dt;

    assign w_fire     = i_cmd_valid && i_res_ready;
    assign o_cmd_pop  = w_fire;
    assign o_res_push = w_fire;

    assign w_wa_min  = sacs_pkg::write_angle(i_cfg.angle_min, i_cfg);
    assign w_wa_max  = sacs_pkg::write_angle(i_cfg.angle_max, i_cfg);
    assign w_wa_rest = sacs_pkg::write_angle(i_cfg.angle_rest, i_cfg);
    assign w_wa_ret  = sacs_pkg::write_angle(r_splash_ret, i_cfg);
    assign w_sum     = {1'b0, i_cfg.angle_min} + {1'b0, i_cfg.angle_max};

    // these modes hold position and are exempt from the safety timeout
    assign w_hold_mode = (i_cfg.mode == sacs_pkg::MODE_PITCH) ||
                         (i_cfg.mode == sacs_pkg::MODE_HIHAT) ||
                         (i_cfg.mode == sacs_pkg::MODE_MUTE)  ||
                         (i_cfg.mode == sacs_pkg::MODE_POSITION);

    assign w_osc_dt = i_cmd.now - r_osc_last;
    assign w_spl_dt = i_cmd.now - r_splash_st;
    assign w_act_dt = i_cmd.now - r_act_st;

    always_comb begin
        n_cur        = r_cur;
        n_splash_on  = r_splash_on;
        n_splash_st  = r_splash_st;
        n_splash_ret = r_splash_ret;
        n_osc_run    = r_osc_run;
        n_osc_phase  = r_osc_phase;
        n_osc_period = r_osc_period;
        n_osc_last   = r_osc_last;
        n_act        = r_act;
        n_act_st     = r_act_st;
        w_move       = 1'b0;
        w_to         = 1'b0;
        unique case (i_cmd.kind)
            sacs_pkg::K_POS, sacs_pkg::K_POS_HIHAT, sacs_pkg::K_PULSE: begin
                if (i_cmd.kind == sacs_pkg::K_POS_HIHAT) n_splash_on = 1'b0;
                n_osc_run = 1'b0;
                n_cur     = i_cmd.angle;
                w_move    = 1'b1;
                n_act     = 1'b1;
                n_act_st  = i_cmd.now;
            end
            sacs_pkg::K_PULSE_HIHAT: begin
                n_splash_ret = i_cmd.angle;
                n_splash_on  = 1'b1;
                n_splash_st  = i_cmd.now;
                n_cur        = w_wa_min;
                w_move       = 1'b1;
                n_act        = 1'b1;
                n_act_st     = i_cmd.now;
            end
            sacs_pkg::K_PULSE_MUTE: begin
                n_cur    = (r_cur <= w_sum[8:1]) ? w_wa_max : w_wa_min;
                w_move   = 1'b1;
                n_act    = 1'b1;
                n_act_st = i_cmd.now;
            end
            sacs_pkg::K_OSC: begin
                n_osc_period = i_cmd.period;
                n_osc_run    = 1'b1;
                n_osc_phase  = !r_osc_phase;
                n_osc_last   = i_cmd.now;
                n_cur        = r_osc_phase ? w_wa_min : w_wa_max;
                w_move       = 1'b1;
                n_act        = 1'b1;
                n_act_st     = i_cmd.now;
            end
            sacs_pkg::K_STOP: begin
                n_osc_run = 1'b0;
                n_cur     = w_wa_rest;
                w_move    = 1'b1;
                n_act     = 1'b0;
            end
            sacs_pkg::K_TICK: begin
                if (r_osc_run && w_osc_dt >= {14'd0, r_osc_period}) begin
                    n_osc_phase = !r_osc_phase;
                    n_osc_last  = i_cmd.now;
                    n_cur       = r_osc_phase ? w_wa_min : w_wa_max;
                    w_move      = 1'b1;
                end else if (r_splash_on && w_spl_dt >= {8'd0, i_cfg.splash_us}) begin
                    n_splash_on = 1'b0;
                    n_cur       = w_wa_ret;
                    w_move      = 1'b1;
                end else if (r_act && !w_hold_mode &&
                             w_act_dt >= {8'd0, i_cfg.max_on_us}) begin
                    n_osc_run = 1'b0;
                    n_cur     = w_wa_rest;
                    w_move    = 1'b1;
                    n_act     = 1'b0;
                    w_to      = 1'b1;
                end
            end
            sacs_pkg::K_INIT: begin
                n_cur      = w_wa_rest;
                w_move     = 1'b1;
                n_osc_run  = 1'b0;
                n_osc_last = i_cmd.now;
            end
            sacs_pkg::K_NOP: begin
                w_move = 1'b0;
            end
            default: begin
                w_move = 1'b0;
            end
        endcase
    end

    assign o_res.move         = w_move;
    assign o_res.angle        = n_cur;
    assign o_res.timeout_stop = w_to;
    assign o_res.active       = n_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= '0;
            r_splash_on  <= 1'b0;
            r_splash_st  <= '0;
            r_splash_ret <= '0;
            r_osc_run    <= 1'b0;
            r_osc_phase  <= 1'b0;
            r_osc_period <= '0;
            r_osc_last   <= '0;
            r_act        <= 1'b0;
            r_act_st     <= '0;
        end else if (w_fire) begin
            r_cur        <= n_cur;
            r_splash_on  <= n_splash_on;
            r_splash_st  <= n_splash_st;
            r_splash_ret <= n_splash_ret;
            r_osc_run    <= n_osc_run;
            r_osc_phase  <= n_osc_phase;
            r_osc_period <= n_osc_period;
            r_osc_last   <= n_osc_last;
            r_act        <= n_act;
            r_act_st     <= n_act_st;
        end
    end

endmodule

FILE: rtl/servo_actuator_command_sequencer_core.sv
// Servo command sequencer core: config registers, front end, queues, back end.
// Depends on sacs_pkg, sacs_fifo, sacs_front, sacs_back and the assertion header.
// Throughput: one request per cycle sustained while the result side keeps popping, set by the execute stage.
// Path of a request: stage A register, stages B and C, the command queue, then the
// execute stage into the result queue, from which it can be popped.
// Reset: synchronous, active low; clears queues and servo state, restores defaults.
`timescale 1ns / 1ps
`include "servo_actuator_command_sequencer_core_assert.svh"
module servo_actuator_command_sequencer_core #(
    parameter int CMD_DEPTH = sacs_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH = sacs_pkg::RES_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [sacs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_opcode,
    input  logic [6:0]  i_value,
    input  logic [31:0] i_now_us,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic        o_move,
    output logic [7:0]  o_angle,
    output logic        o_timeout_stop,
    output logic        o_active
);
    localparam int CMD_W = $bits(sacs_pkg::t_cmd);
    localparam int RES_W = $bits(sacs_pkg::t_res);

    // Configuration. The user must make writes land only while the block is idle, as the
    // block does not enforce it; so every stage may read these registers live, no copy per request.
    sacs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= sacs_pkg::MODE_STRIKE;
            r_cfg.angle_min  <= sacs_pkg::RST_ANGLE_MIN;
            r_cfg.angle_max  <= sacs_pkg::RST_ANGLE_MAX;
            r_cfg.angle_rest <= sacs_pkg::RST_ANGLE_REST;
            r_cfg.mirror     <= 1'b0;
            r_cfg.enable     <= 1'b1;
            r_cfg.splash_us  <= sacs_pkg::RST_SPLASH_US;
            r_cfg.max_on_us  <= sacs_pkg::RST_MAX_ON_US;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sacs_pkg::REG_MODE:       r_cfg.mode       <= i_cfg_data[2:0];
                sacs_pkg::REG_ANGLE_MIN:  r_cfg.angle_min  <= i_cfg_data[7:0];
                sacs_pkg::REG_ANGLE_MAX:  r_cfg.angle_max  <= i_cfg_data[7:0];
                sacs_pkg::REG_ANGLE_REST: r_cfg.angle_rest <= i_cfg_data[7:0];
                sacs_pkg::REG_MIRROR:     r_cfg.mirror     <= i_cfg_data[0];
                sacs_pkg::REG_ENABLE:     r_cfg.enable     <= i_cfg_data[0];
                sacs_pkg::REG_SPLASH_US:  r_cfg.splash_us  <= i_cfg_data[23:0];
                sacs_pkg::REG_MAX_ON_US:  r_cfg.max_on_us  <= i_cfg_data[23:0];
                default:                  r_cfg.mode       <= r_cfg.mode;
            endcase
        end
    end

    // Front end: request register, multiply, reciprocal divide and oscillation period, final angle.
    // Everything that depends only on the request and the config is done here,
    // including tracking the last hi-hat controller value.
    logic            w_cmd_push, w_cmd_full, w_cmd_empty, w_cmd_pop;
    sacs_pkg::t_cmd  w_front_cmd, w_cmd_head;
    logic [CMD_W-1:0] w_cmd_rdata;

    sacs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .o_full      (full),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_now_us    (i_now_us),
        .o_cmd_valid (w_cmd_push),
        .i_cmd_ready (!w_cmd_full),
        .o_cmd       (w_front_cmd)
    );

    // Command queue decouples the front pipeline from the execute stage.
    sacs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_wdata (w_front_cmd),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_rdata (w_cmd_rdata),
        .o_empty (w_cmd_empty)
    );

    assign w_cmd_head = sacs_pkg::t_cmd'(w_cmd_rdata);

    // Back end: servo state (oscillator, splash, activation timer), one
    // command per cycle while the result queue has room, one result per command.
    logic            w_res_push, w_res_full;
    sacs_pkg::t_res  w_back_res, w_res_out;
    logic [RES_W-1:0] w_res_rdata;

    sacs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!w_cmd_empty),
        .i_cmd       (w_cmd_head),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_ready (!w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_back_res)
    );

    // Result queue: results wait here so the back end keeps going under pop stalls until it fills.
    sacs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_back_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (w_res_rdata),
        .o_empty (empty)
    );

    assign w_res_out      = sacs_pkg::t_res'(w_res_rdata);
    assign o_move         = w_res_out.move;
    assign o_angle        = w_res_out.angle;
    assign o_timeout_stop = w_res_out.timeout_stop;
    assign o_active       = w_res_out.active;

    // ---- assertions
    // a command offered to a full queue stays offered
    `SACS_ASSERT_NEXT(a_cmd_held, i_clk, i_rst_n, w_cmd_push && w_cmd_full, w_cmd_push, "command dropped while queue full")
    `SACS_ASSERT_IMPL(a_res_no_overflow, i_clk, i_rst_n, w_res_push, !w_res_full, "result queue overflow")
    `SACS_ASSERT_NEXT(a_res_visible, i_clk, i_rst_n, w_res_push, !empty, "pushed result not visible")
    `SACS_ASSERT_IMPL(a_timeout_stops, i_clk, i_rst_n, !empty && o_timeout_stop, o_move && !o_active, "timeout without stop")

endmodule

FILE: bench/servo_actuator_command_sequencer_core_tb.sv
// Testbench for servo_actuator_command_sequencer_core: directed and random requests,
// each result checked against an in-bench model of the servo sequencing rules.
// Depends on sacs_pkg and the core RTL; self-contained otherwise.
`timescale 1ns / 1ps
module servo_actuator_command_sequencer_core_tb;
    import sacs_pkg::*;

    // codes the package leaves unnamed
    localparam logic [2:0] OP_SPARE_A   = 3'd6;
    localparam logic [2:0] OP_SPARE_B   = 3'd7;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;

    localparam int HOLD_CYCLES  = 300;     // long receiver stall, fills the block
    localparam int DRAIN_CYCLES = 12;      // margin before the final check
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_ITEMS  = 35;
    localparam int PRINT_CAP    = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [2:0]            i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    logic [2:0]            i_opcode;
    logic [6:0]            i_value;
    logic [31:0]           i_now_us;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_move;
    logic [7:0]            o_angle;
    logic                  o_timeout_stop;
    logic                  o_active;

    servo_actuator_command_sequencer_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .i_now_us       (i_now_us),
        .empty          (empty),
        .pop            (pop),
        .o_move         (o_move),
        .o_angle        (o_angle),
        .o_timeout_stop (o_timeout_stop),
        .o_active       (o_active)
    );

    // ------------------------------------------------------------------
    // Servo model: register copy plus sequencer state
    // ------------------------------------------------------------------
    t_cfg        cfg;
    logic [7:0]  cur_ang;       // angle last written to the servo
    logic [6:0]  cc_last;       // hihat controller value
    logic        spl_on;        // hihat splash open
    logic [31:0] spl_t0;
    logic [7:0]  spl_back;      // angle to return to when the splash closes
    logic        osc_on;
    logic        osc_hi;
    logic [17:0] osc_per;
    logic [31:0] osc_t_last;
    logic        act_on;        // activation flag, feeds the safety timeout
    logic [31:0] act_t0;
    logic        step_moved;

    t_res        servo_out_q[$];   // predicted results, oldest first

    int          mismatches = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 8;
    int          recv_idle_pct = 47;
    logic        rx_held = 1'b0;
    logic [31:0] us_now;
    event        start_hold;

    // clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("ERROR: %0t ns %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // integer linear map, division truncates toward zero
    function automatic longint map_lin(input longint x, input longint a, input longint b,
                                       input longint c, input longint d);
        return (x - a) * (d - c) / (b - a) + c;
    endfunction

    function automatic logic [7:0] scale_val(input logic [6:0] x);
        longint r;
        r = map_lin(longint'(x), 0, VAL_TOP, longint'(cfg.angle_min), longint'(cfg.angle_max));
        return r[7:0];
    endfunction

    // clamp low then high (so max wins when min > max), then optional mirror
    function automatic logic [7:0] fit_angle(input logic [7:0] a);
        longint v;
        longint lo;
        longint hi;
        v  = longint'(a);
        lo = longint'(cfg.angle_min);
        hi = longint'(cfg.angle_max);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        if (cfg.mirror) v = hi - (v - lo);
        return v[7:0];
    endfunction

    task automatic drive_to(input logic [7:0] a);
        cur_ang    = fit_angle(a);
        step_moved = 1'b1;
    endtask

    task automatic rest_stop();
        osc_on = 1'b0;
        drive_to(cfg.angle_rest);
        act_on = 1'b0;
    endtask

    task automatic arm(input logic [31:0] t);
        act_on = 1'b1;
        act_t0 = t;
    endtask

    // Advance the model by one accepted request and queue the result it gives.
    task automatic servo_step(input logic [2:0] op, input logic [6:0] val,
                              input logic [31:0] t);
        t_res       res;
        logic [7:0] tgt;
        logic [8:0] mid9;
        longint     lo;
        longint     hi;
        longint     ctr;
        longint     half;
        longint     pos;
        longint     per;
        logic       stopped;
        step_moved = 1'b0;
        stopped    = 1'b0;
        lo         = longint'(cfg.angle_min);
        hi         = longint'(cfg.angle_max);
        case (op)
            OP_POSITION: if (cfg.enable) begin
                if (cfg.mode == MODE_PITCH) begin
                    // bend around the center of the range
                    ctr  = (lo + hi) / 2;
                    half = (hi - lo) / 2;
                    pos  = ctr + map_lin(longint'(val), 0, VAL_TOP, -half, half);
                    if (pos < lo) pos = lo;
                    if (pos > hi) pos = hi;
                    tgt = pos[7:0];
                end else if (cfg.mode == MODE_HIHAT) begin
                    cc_last = val;
                    tgt     = scale_val(val);
                    spl_on  = 1'b0;
                end else if (cfg.mode == MODE_MUTE) begin
                    tgt = (val < VAL_MID) ? cfg.angle_min : cfg.angle_max;
                end else begin
                    tgt = scale_val(val);
                end
                osc_on = 1'b0;
                drive_to(tgt);
                arm(t);
            end
            OP_PULSE: if (cfg.enable) begin
                if (cfg.mode == MODE_HIHAT) begin
                    spl_back = scale_val(cc_last);
                    spl_on   = 1'b1;
                    spl_t0   = t;
                    drive_to(cfg.angle_min);
                end else if (cfg.mode == MODE_MUTE) begin
                    // toggle between the range ends
                    mid9 = ({1'b0, cfg.angle_min} + {1'b0, cfg.angle_max}) >> 1;
                    drive_to(({1'b0, cur_ang} <= mid9) ? cfg.angle_max : cfg.angle_min);
                end else begin
                    osc_on = 1'b0;
                    drive_to(scale_val(val));
                end
                arm(t);
            end
            OP_OSC: if (cfg.enable && (cfg.mode == MODE_STRIKE || cfg.mode == MODE_COMB)) begin
                if (val == '0) begin
                    rest_stop();
                end else begin
                    per = map_lin(longint'(val), 1, VAL_TOP, OSC_SLOW_US, OSC_FAST_US);
                    if (per < OSC_FAST_US) per = OSC_FAST_US;
                    osc_per    = per[17:0];
                    osc_on     = 1'b1;
                    osc_hi     = ~osc_hi;
                    osc_t_last = t;
                    drive_to(osc_hi ? cfg.angle_max : cfg.angle_min);
                    arm(t);
                end
            end
            OP_OFF: if (cfg.enable) rest_stop();
            OP_TICK: begin
                // oscillation step first, then splash close, then safety timeout
                if (osc_on && (t - osc_t_last) >= 32'(osc_per)) begin
                    osc_hi     = ~osc_hi;
                    osc_t_last = t;
                    drive_to(osc_hi ? cfg.angle_max : cfg.angle_min);
                end else if (spl_on && (t - spl_t0) >= 32'(cfg.splash_us)) begin
                    spl_on = 1'b0;
                    drive_to(spl_back);
                end else if (act_on && (cfg.mode < MODE_PITCH || cfg.mode > MODE_POSITION)
                             && (t - act_t0) >= 32'(cfg.max_on_us)) begin
                    rest_stop();
                    stopped = 1'b1;
                end
            end
            OP_INIT: begin
                // enable has no say here; activation is left alone
                drive_to(cfg.angle_rest);
                osc_on     = 1'b0;
                osc_t_last = t;
            end
            default: ;
        endcase
        res.move         = step_moved;
        res.angle        = cur_ang;
        res.timeout_stop = stopped;
        res.active       = act_on;
        servo_out_q.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Result side: check each popped result, idle or stall at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_side
        t_res want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (servo_out_q.size() == 0) begin
                    report_mismatch("result with no request pending, angle", o_angle, -1);
                end else begin
                    want = servo_out_q.pop_front();
                    if (o_move !== want.move)
                        report_mismatch("move", o_move, want.move);
                    if (o_angle !== want.angle)
                        report_mismatch("angle", o_angle, want.angle);
                    if (o_timeout_stop !== want.timeout_stop)
                        report_mismatch("timeout_stop", o_timeout_stop, want.timeout_stop);
                    if (o_active !== want.active)
                        report_mismatch("active", o_active, want.active);
                end
            end
            if (rx_held) pop <= 1'b0;
            else         pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver stall, counted here
    initial begin
        forever begin
            @(start_hold);
            rx_held = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_held = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one request; returns right after the edge that took it.
    task automatic send_request(input logic [2:0] op, input logic [6:0] val,
                                input logic [31:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        i_now_us <= t;
        do @(posedge i_clk); while (full);
        servo_step(op, val, t);
    endtask

    // Stop offering until every predicted result has been popped.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (servo_out_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_MODE:       cfg.mode       = data[2:0];
            REG_ANGLE_MIN:  cfg.angle_min  = data[7:0];
            REG_ANGLE_MAX:  cfg.angle_max  = data[7:0];
            REG_ANGLE_REST: cfg.angle_rest = data[7:0];
            REG_MIRROR:     cfg.mirror     = data[0];
            REG_ENABLE:     cfg.enable     = data[0];
            REG_SPLASH_US:  cfg.splash_us  = data[23:0];
            REG_MAX_ON_US:  cfg.max_on_us  = data[23:0];
            default: ;
        endcase
    endtask

    // Mostly ticks and commands on a rising clock, now and then a jump in time.
    task automatic random_request();
        int         pick;
        logic [2:0] op;
        logic [6:0] val;
        pick = $urandom_range(99);
        if (pick < 35)      op = OP_TICK;
        else if (pick < 52) op = OP_POSITION;
        else if (pick < 67) op = OP_PULSE;
        else if (pick < 82) op = OP_OSC;
        else if (pick < 88) op = OP_OFF;
        else if (pick < 94) op = OP_INIT;
        else                op = pick[0] ? OP_SPARE_A : OP_SPARE_B;
        case ($urandom_range(7))
            0:       val = '0;
            1:       val = 7'(VAL_TOP);
            default: val = 7'($urandom_range(VAL_TOP));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: us_now += 32'($urandom_range(40000));
            4, 5, 6, 7: us_now += 32'($urandom_range(300000));
            8:          us_now += 32'($urandom_range(6000000));
            default:    us_now = $urandom();
        endcase
        send_request(op, val, us_now);
    endtask

    // Per-phase register set; phases 0 and 1 take the extremes, phase 9 a zero-width range.
    task automatic load_phase_config(input int p);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  rest_a;
        logic [23:0] spl;
        logic [23:0] lim;
        if (p == 0) begin
            lo = 8'd0;   hi = 8'd180; rest_a = 8'd0;   spl = '0; lim = '0;
        end else if (p == 1) begin
            // min above max
            lo = 8'd180; hi = 8'd0;   rest_a = 8'd180; spl = '1; lim = '1;
        end else if (p == 9) begin
            lo = 8'd90;  hi = 8'd90;  rest_a = 8'($urandom_range(180));
            spl = 24'($urandom_range(200000)); lim = 24'($urandom_range(400000));
        end else begin
            lo     = 8'($urandom_range(120));
            hi     = 8'($urandom_range(180, lo));
            rest_a = 8'($urandom_range(180));
            spl    = 24'($urandom_range(200000));
            lim    = 24'($urandom_range(400000));
        end
        write_reg(REG_MODE, 24'(p % 8));
        write_reg(REG_ANGLE_MIN, 24'(lo));
        write_reg(REG_ANGLE_MAX, 24'(hi));
        write_reg(REG_ANGLE_REST, 24'(rest_a));
        write_reg(REG_MIRROR, 24'(p % 2));
        write_reg(REG_ENABLE, 24'(p != 6));
        write_reg(REG_SPLASH_US, spl);
        write_reg(REG_MAX_ON_US, lim);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings (strike mode): every opcode, time wrap, oscillation, timeout.
    task automatic test_strike_directed();
        send_request(OP_TICK,     7'd0,   32'd0);           // nothing active
        send_request(OP_INIT,     7'd127, 32'hFFFF_FFFF);
        send_request(OP_POSITION, 7'd127, 32'd10);
        send_request(OP_POSITION, 7'd0,   32'd20);
        send_request(OP_PULSE,    7'd64,  32'd30);
        send_request(OP_OSC,      7'd127, 32'd1000);        // fastest period
        send_request(OP_TICK,     7'd0,   32'd20000);       // not due yet
        send_request(OP_TICK,     7'd0,   32'd31000);       // due
        send_request(OP_OSC,      7'd0,   32'd32000);       // zero rate stops
        send_request(OP_OSC,      7'd1,   32'hFFFF_0000);   // slowest period
        send_request(OP_TICK,     7'd0,   32'h0004_0000);   // due across the wrap
        send_request(OP_OFF,      7'd0,   32'h0004_0010);
        send_request(OP_SPARE_A,  7'd127, 32'h0004_0020);
        send_request(OP_SPARE_B,  7'd127, 32'h0004_0030);
        send_request(OP_POSITION, 7'd64,  32'd100);
        send_request(OP_TICK,     7'd0,   32'd5_000_099);   // one short of timeout
        send_request(OP_TICK,     7'd0,   32'd5_000_100);   // safety stop
    endtask

    // Enable gating, hihat splash, mute toggle, pitch bend, spare mode, min above max.
    task automatic test_mode_specials();
        write_reg(REG_ENABLE, '0);
        send_request(OP_POSITION, 7'd127, 32'd200);         // ignored
        send_request(OP_INIT,     7'd0,   32'd210);         // still acts
        write_reg(REG_ENABLE, 24'd1);
        write_reg(REG_SPLASH_US, 24'd1000);
        write_reg(REG_MODE, 24'(MODE_HIHAT));
        send_request(OP_POSITION, 7'd100, 32'd300);
        send_request(OP_PULSE,    7'd0,   32'd310);
        send_request(OP_TICK,     7'd0,   32'd800);
        send_request(OP_TICK,     7'd0,   32'd1310);        // splash closes
        write_reg(REG_MODE, 24'(MODE_MUTE));
        send_request(OP_POSITION, 7'd10,  32'd1400);
        send_request(OP_PULSE,    7'd0,   32'd1410);
        send_request(OP_PULSE,    7'd0,   32'd1420);
        write_reg(REG_MODE, 24'(MODE_PITCH));
        send_request(OP_POSITION, 7'd0,   32'd1500);
        send_request(OP_POSITION, 7'd127, 32'd1510);
        send_request(OP_OSC,      7'd50,  32'd1520);        // no oscillation here
        write_reg(REG_MODE, 24'(MODE_SPARE_A));
        write_reg(REG_MAX_ON_US, '0);
        send_request(OP_POSITION, 7'd30,  32'd2000);
        send_request(OP_TICK,     7'd0,   32'd2000);        // zero timeout trips at once
        write_reg(REG_MODE, 24'(MODE_POSITION));
        send_request(OP_POSITION, 7'd30,  32'd2100);
        send_request(OP_TICK,     7'd0,   32'd2100);        // holding mode, no timeout
        write_reg(REG_ANGLE_MIN, 24'd150);
        write_reg(REG_ANGLE_MAX, 24'd30);
        write_reg(REG_ANGLE_REST, 24'd10);
        write_reg(REG_MIRROR, 24'd1);
        send_request(OP_POSITION, 7'd0,   32'd2200);
        send_request(OP_INIT,     7'd0,   32'd2210);
    endtask

    task automatic test_random_traffic(input int first_phase, input int phases,
                                       input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int p = first_phase; p < first_phase + phases; p++) begin
            load_phase_config(p);
            us_now = $urandom();
            repeat (PHASE_ITEMS) random_request();
        end
    endtask

    // Receiver stalls long while requests keep coming: full must hold them off.
    task automatic test_full_queue();
        send_idle_pct = 0;
        wait_idle();
        -> start_hold;
        repeat (30) random_request();
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_MODE;
        i_cfg_data = '0;
        push       = 1'b0;
        i_opcode   = OP_POSITION;
        i_value    = '0;
        i_now_us   = '0;

        cfg.mode       = MODE_STRIKE;
        cfg.angle_min  = RST_ANGLE_MIN;
        cfg.angle_max  = RST_ANGLE_MAX;
        cfg.angle_rest = RST_ANGLE_REST;
        cfg.mirror     = 1'b0;
        cfg.enable     = 1'b1;
        cfg.splash_us  = RST_SPLASH_US;
        cfg.max_on_us  = RST_MAX_ON_US;
        cur_ang    = '0;
        cc_last    = '0;
        spl_on     = 1'b0;
        spl_t0     = '0;
        spl_back   = '0;
        osc_on     = 1'b0;
        osc_hi     = 1'b0;
        osc_per    = '0;
        osc_t_last = '0;
        act_on     = 1'b0;
        act_t0     = '0;
        us_now     = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_strike_directed();
        test_mode_specials();
        test_random_traffic(0, 4, 8, 47);   // sender mostly busy, receiver lazy
        test_full_queue();
        test_random_traffic(4, 3, 47, 8);   // roles swapped
        test_random_traffic(7, 3, 0, 0);    // back to back

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && servo_out_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
